@@ rtl/kcec_pkg.sv @@
package kcec_pkg;

	localparam int unsigned STATE_W = 3;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned TICKS_W = 8;

	localparam logic [TIME_W-1:0]  STEP_SECONDS     = TIME_W'(60);
	localparam logic [TICKS_W-1:0] LONG_PRESS_RESET = TICKS_W'(3);

	typedef enum logic [STATE_W-1:0] {
		ST_CLK_IDLE  = 3'd0,
		ST_CLK_PRESS = 3'd1,
		ST_CLK_LONG  = 3'd2,
		ST_EDT_IDLE  = 3'd3,
		ST_EDT_PRESS = 3'd4,
		ST_EDT_LONG  = 3'd5,
		ST_ALT       = 3'd6
	} ui_state_t;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_RIGHT   = 2'd2,
		EV_LEFT    = 2'd3
	} ui_event_t;

endpackage

@@ rtl/knob_clock_edit_controller.sv @@
// Knob clock edit controller. Each input transaction is one poll of a rotary encoder with a
// push key: lines A and B, the key level, a long-press tick and the current epoch seconds.
// A change of A since the previous poll is a step (right when B differs from A, else left);
// otherwise the poll is a key-down or key-up event. The very first poll after reset only
// captures A and reports the mode with every other field zero. In clock mode a step pulses
// enter and shows the alternate display (a further step leaves it with a leave pulse); a key
// held for long_press_ticks ticks and then released enters edit mode, pulses enter and
// captures now_seconds. In edit mode a right step subtracts 60 s and a left step adds 60 s,
// each reported on shown_valid/shown_time. A short press then leaves and, if the time was
// stepped, commits it with the seconds zeroed; a long press leaves without committing. A tick
// counts in the same poll that starts the hold; long_press_ticks of 0 acts as 1. Each poll
// yields exactly one result transaction. Timing: the poll lands in an input register, the
// state machine and timer update into the result register, and a new poll is accepted
// every cycle as long as the result side keeps taking results. The seconds residue for the
// commit is folded out of the edited time itself with a short nibble sum (a step that wraps
// past 2^32 shifts the residue), followed by one 32-bit subtract. long_press_ticks may only
// be written while no poll is in flight.
module knob_clock_edit_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [kcec_pkg::TICKS_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         enc_a,
	input  logic                         enc_b,
	input  logic                         key_down,
	input  logic                         tick,
	input  logic [kcec_pkg::TIME_W-1:0]  now_seconds,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [kcec_pkg::STATE_W-1:0] mode,
	output logic                         enter_pulse,
	output logic                         leave_pulse,
	output logic                         display_clear,
	output logic                         shown_valid,
	output logic [kcec_pkg::TIME_W-1:0]  shown_time,
	output logic                         commit_valid,
	output logic [kcec_pkg::TIME_W-1:0]  commit_time
);
	import kcec_pkg::*;

	// input stage
	logic              valid_s1;
	logic              enc_a_s1;
	logic              enc_b_s1;
	logic              key_s1;
	logic              tick_s1;
	logic [TIME_W-1:0] now_s1;

	// controller state
	ui_state_t          state_q;
	logic               last_a_q;
	logic               primed_q;
	logic [TICKS_W-1:0] hold_cnt_q;
	logic               hold_on_q;
	logic               changed_q;
	logic [TIME_W-1:0]  edited_q;
	logic [TICKS_W-1:0] long_ticks_q;

	// result register
	logic              out_valid_q;
	ui_state_t         mode_q;
	logic              enter_q;
	logic              leave_q;
	logic              clear_q;
	logic              shown_v_q;
	logic [TIME_W-1:0] shown_t_q;
	logic              commit_v_q;
	logic [TIME_W-1:0] commit_t_q;

	logic advance;
	logic act;

	ui_event_t ev;
	ui_state_t st_evt;
	ui_state_t st_next;

	logic              o_enter;
	logic              o_leave;
	logic              o_clear;
	logic              o_shown;
	logic              o_commit;
	logic              capture;
	logic              timer_start;
	logic              timer_stop;
	logic [TIME_W-1:0] stepped_time;

	logic [TICKS_W-1:0] cnt_evt;
	logic               on_evt;
	logic [TICKS_W-1:0] cnt_inc;
	logic [TICKS_W-1:0] limit;
	logic               expire;

	logic [6:0] nib_sum;
	logic [4:0] fold;
	logic [3:0] rem15;
	logic [5:0] rem60;

	// advance the input stage whenever the result register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign act      = advance && primed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			enc_a_s1 <= enc_a;
			enc_b_s1 <= enc_b;
			key_s1   <= key_down;
			tick_s1  <= tick;
			now_s1   <= now_seconds;
		end
	end

	// event from the poll: a change on A is a step, else the key level
	always_comb begin
		if (enc_a_s1 != last_a_q) begin
			ev = (enc_b_s1 != enc_a_s1) ? EV_RIGHT : EV_LEFT;
		end else begin
			ev = key_s1 ? EV_PRESS : EV_RELEASE;
		end
	end

	// next state: poll event first, then the long-press timeout
	always_comb begin
		st_evt = state_q;
		case (state_q)
			ST_CLK_IDLE: begin
				if (ev == EV_PRESS) st_evt = ST_CLK_PRESS;
				else if (ev == EV_RIGHT || ev == EV_LEFT) st_evt = ST_ALT;
			end
			ST_CLK_PRESS: begin
				if (ev == EV_RELEASE) st_evt = ST_CLK_IDLE;
			end
			ST_CLK_LONG: begin
				if (ev == EV_RELEASE) st_evt = ST_EDT_IDLE;
			end
			ST_EDT_IDLE: begin
				if (ev == EV_PRESS) st_evt = ST_EDT_PRESS;
			end
			ST_EDT_PRESS: begin
				if (ev == EV_RELEASE) st_evt = ST_CLK_IDLE;
			end
			ST_EDT_LONG: begin
				if (ev == EV_RELEASE) st_evt = ST_CLK_IDLE;
			end
			ST_ALT: begin
				if (ev == EV_RIGHT || ev == EV_LEFT) st_evt = ST_CLK_IDLE;
			end
			default: st_evt = ST_CLK_IDLE;
		endcase

		st_next = st_evt;
		if (expire) begin
			case (st_evt)
				ST_CLK_PRESS: st_next = ST_CLK_LONG;
				ST_EDT_PRESS: st_next = ST_EDT_LONG;
				default:      st_next = st_evt;
			endcase
		end
	end

	// per-poll actions of the state machine
	always_comb begin
		o_enter     = 1'b0;
		o_leave     = 1'b0;
		o_clear     = 1'b0;
		o_shown     = 1'b0;
		o_commit    = 1'b0;
		capture     = 1'b0;
		timer_start = 1'b0;
		timer_stop  = 1'b0;
		case (state_q)
			ST_CLK_IDLE: begin
				if (ev == EV_PRESS) begin
					timer_start = 1'b1;
				end else if (ev == EV_RIGHT || ev == EV_LEFT) begin
					o_enter = 1'b1;
					o_clear = 1'b1;
				end
			end
			ST_CLK_PRESS: begin
				timer_stop = (ev == EV_RELEASE);
			end
			ST_CLK_LONG: begin
				if (ev == EV_RELEASE) begin
					o_enter = 1'b1;
					capture = 1'b1;
				end
			end
			ST_EDT_IDLE: begin
				if (ev == EV_PRESS) timer_start = 1'b1;
				else if (ev == EV_RIGHT || ev == EV_LEFT) o_shown = 1'b1;
			end
			ST_EDT_PRESS: begin
				if (ev == EV_RELEASE) begin
					timer_stop = 1'b1;
					o_leave    = 1'b1;
					o_commit   = changed_q;
				end
			end
			ST_EDT_LONG: begin
				o_leave = (ev == EV_RELEASE);
			end
			ST_ALT: begin
				o_leave = (ev == EV_RIGHT || ev == EV_LEFT);
			end
			default: begin
				o_leave = 1'b0;
			end
		endcase
	end

	assign stepped_time = (ev == EV_RIGHT) ? edited_q - STEP_SECONDS
	                                       : edited_q + STEP_SECONDS;

	// hold timer: event effect, then the tick (saturating count)
	always_comb begin
		cnt_evt = hold_cnt_q;
		on_evt  = hold_on_q;
		if (timer_start) begin
			cnt_evt = '0;
			on_evt  = 1'b1;
		end else if (timer_stop) begin
			cnt_evt = '0;
			on_evt  = 1'b0;
		end
		cnt_inc = (&cnt_evt) ? cnt_evt : cnt_evt + TICKS_W'(1);
		limit   = (long_ticks_q == '0) ? TICKS_W'(1) : long_ticks_q;
		expire  = tick_s1 && on_evt && (cnt_inc >= limit);
	end

	// seconds residue of the edited time: x mod 60 = 4 * ((x >> 2) mod 15) + x[1:0],
	// and the mod 15 is a nibble sum since 16 leaves 1
	always_comb begin
		nib_sum = 7'(edited_q[5:2]) + 7'(edited_q[9:6]) + 7'(edited_q[13:10])
		        + 7'(edited_q[17:14]) + 7'(edited_q[21:18]) + 7'(edited_q[25:22])
		        + 7'(edited_q[29:26]) + 7'(edited_q[31:30]);
		fold    = 5'(nib_sum[3:0]) + 5'(nib_sum[6:4]);
		rem15   = (fold >= 5'd15) ? 4'(fold - 5'd15) : fold[3:0];
		rem60   = {rem15, edited_q[1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q <= LONG_PRESS_RESET;
		end else if (cfg_wr_en) begin
			long_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLK_IDLE;
			last_a_q   <= 1'b0;
			primed_q   <= 1'b0;
			hold_cnt_q <= '0;
			hold_on_q  <= 1'b0;
			changed_q  <= 1'b0;
			edited_q   <= '0;
		end else if (advance) begin
			last_a_q <= enc_a_s1;
			primed_q <= 1'b1;
			if (primed_q) begin
				state_q <= st_next;
				if (expire) begin
					hold_cnt_q <= '0;
					hold_on_q  <= 1'b0;
				end else if (tick_s1 && on_evt) begin
					hold_cnt_q <= cnt_inc;
					hold_on_q  <= on_evt;
				end else begin
					hold_cnt_q <= cnt_evt;
					hold_on_q  <= on_evt;
				end
				if (capture) begin
					changed_q <= 1'b0;
					edited_q  <= now_s1;
				end else if (o_shown) begin
					changed_q <= 1'b1;
					edited_q  <= stepped_time;
				end
			end
		end
	end

	// result register: hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_q     <= primed_q ? st_next : state_q;
			enter_q    <= act && o_enter;
			leave_q    <= act && o_leave;
			clear_q    <= act && o_clear;
			shown_v_q  <= act && o_shown;
			shown_t_q  <= (act && o_shown) ? stepped_time : '0;
			commit_v_q <= act && o_commit;
			commit_t_q <= (act && o_commit) ? edited_q - TIME_W'(rem60) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign mode          = mode_q;
	assign enter_pulse   = enter_q;
	assign leave_pulse   = leave_q;
	assign display_clear = clear_q;
	assign shown_valid   = shown_v_q;
	assign shown_time    = shown_t_q;
	assign commit_valid  = commit_v_q;
	assign commit_time   = commit_t_q;

endmodule

@@ rtl/kcec_checker.sv @@
module kcec_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [kcec_pkg::STATE_W-1:0] mode,
	input logic                         enter_pulse,
	input logic                         leave_pulse,
	input logic                         display_clear,
	input logic                         shown_valid,
	input logic                         commit_valid,
	input logic [kcec_pkg::TIME_W-1:0]  commit_time
);
	import kcec_pkg::*;

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(commit_time)
			&& $stable(commit_valid) && $stable(leave_pulse))
		else $error("result changed while stalled");

	// a commit only comes with leaving edit mode back to clock idle
	a_commit_leave: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && commit_valid |-> leave_pulse && mode == ST_CLK_IDLE)
		else $error("commit without leave to clock idle");

	// entering the alternate display also pulses enter
	a_clear_alt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && display_clear |-> enter_pulse && mode == ST_ALT)
		else $error("display clear outside alternate display entry");

	// edit steps leave the machine in edit idle and never pulse enter or leave
	a_shown_edit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shown_valid |-> mode == ST_EDT_IDLE && !enter_pulse && !leave_pulse)
		else $error("shown time outside edit idle");

endmodule

bind knob_clock_edit_controller kcec_checker u_kcec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.mode          (mode),
	.enter_pulse   (enter_pulse),
	.leave_pulse   (leave_pulse),
	.display_clear (display_clear),
	.shown_valid   (shown_valid),
	.commit_valid  (commit_valid),
	.commit_time   (commit_time)
);

@@ bench/knob_clock_edit_controller_test.sv @@
`timescale 1ns / 100ps

module knob_clock_edit_controller_test;
	import kcec_pkg::*;

	// One poll as it crosses the input channel.
	typedef struct packed {
		logic              a;
		logic              b;
		logic              key;
		logic              tk;
		logic [TIME_W-1:0] now;
	} knob_poll_t;

	// One result transaction, field for field as the output channel carries it.
	typedef struct {
		logic [STATE_W-1:0] mode;
		logic               enter;
		logic               leave;
		logic               clear;
		logic               shown_v;
		logic [TIME_W-1:0]  shown_t;
		logic               commit_v;
		logic [TIME_W-1:0]  commit_t;
	} ui_result_t;

	// Tracks the knob UI state machine and holds the results it predicts, oldest first.
	class ui_result_tracker;
		ui_state_t          ui;
		logic               last_a;
		logic               primed;
		logic [TICKS_W-1:0] hold_cnt;
		logic               timer_on;
		logic               changed;
		logic [TIME_W-1:0]  edited;
		logic [TICKS_W-1:0] press_ticks;
		ui_result_t         cur;
		ui_result_t         predicted_results[$];
		int                 mismatches;
		int                 results_seen;

		function new();
			ui           = ST_CLK_IDLE;
			last_a       = 1'b0;
			primed       = 1'b0;
			hold_cnt     = '0;
			timer_on     = 1'b0;
			changed      = 1'b0;
			edited       = '0;
			press_ticks  = LONG_PRESS_RESET;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function int pending();
			return predicted_results.size();
		endfunction

		function int hold_limit();
			return (press_ticks == 0) ? 1 : int'(press_ticks);
		endfunction

		function void start_hold();
			hold_cnt = '0;
			timer_on = 1'b1;
		endfunction

		function void stop_hold();
			hold_cnt = '0;
			timer_on = 1'b0;
		endfunction

		function void take_event(ui_event_t ev, logic [TIME_W-1:0] now);
			case (ui)
				ST_CLK_IDLE: begin
					if (ev == EV_PRESS) begin
						ui = ST_CLK_PRESS;
						start_hold();
					end else if (ev == EV_RIGHT || ev == EV_LEFT) begin
						cur.enter = 1'b1;
						cur.clear = 1'b1;
						ui = ST_ALT;
					end
				end
				ST_CLK_PRESS: begin
					if (ev == EV_RELEASE) begin
						stop_hold();
						ui = ST_CLK_IDLE;
					end
				end
				ST_CLK_LONG: begin
					if (ev == EV_RELEASE) begin
						cur.enter = 1'b1;
						ui = ST_EDT_IDLE;
						changed = 1'b0;
						edited = now;
					end
				end
				ST_EDT_IDLE: begin
					if (ev == EV_PRESS) begin
						ui = ST_EDT_PRESS;
						start_hold();
					end else if (ev == EV_RIGHT || ev == EV_LEFT) begin
						changed = 1'b1;
						edited = (ev == EV_RIGHT) ? edited - STEP_SECONDS : edited + STEP_SECONDS;
						cur.shown_v = 1'b1;
						cur.shown_t = edited;
					end
				end
				ST_EDT_PRESS: begin
					if (ev == EV_RELEASE) begin
						stop_hold();
						if (changed) begin
							cur.commit_v = 1'b1;
							cur.commit_t = edited - (edited % STEP_SECONDS);
						end
						cur.leave = 1'b1;
						ui = ST_CLK_IDLE;
					end
				end
				ST_EDT_LONG: begin
					if (ev == EV_RELEASE) begin
						cur.leave = 1'b1;
						ui = ST_CLK_IDLE;
					end
				end
				ST_ALT: begin
					if (ev == EV_RIGHT || ev == EV_LEFT) begin
						cur.leave = 1'b1;
						ui = ST_CLK_IDLE;
					end
				end
				default: ui = ST_CLK_IDLE;
			endcase
		endfunction

		function void hold_expired();
			if (ui == ST_CLK_PRESS)
				ui = ST_CLK_LONG;
			else if (ui == ST_EDT_PRESS)
				ui = ST_EDT_LONG;
		endfunction

		function void note_poll(knob_poll_t p);
			ui_event_t ev;
			cur = '{default: '0};
			if (!primed) begin
				primed = 1'b1;
				last_a = p.a;
			end else begin
				if (p.a != last_a)
					ev = (p.b != p.a) ? EV_RIGHT : EV_LEFT;
				else
					ev = p.key ? EV_PRESS : EV_RELEASE;
				last_a = p.a;
				take_event(ev, p.now);
				if (p.tk && timer_on) begin
					if (hold_cnt != '1)
						hold_cnt = hold_cnt + 1'b1;
					if (int'(hold_cnt) >= hold_limit()) begin
						stop_hold();
						hold_expired();
					end
				end
			end
			cur.mode = ui;
			predicted_results.push_back(cur);
		endfunction

		task report_mismatch(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
			mismatches++;
			$display("mismatch on %s in result %0d: expected %0h, got %0h",
				what, results_seen, want, got);
		endtask

		task check_result(ui_result_t r);
			ui_result_t want;
			results_seen++;
			if (predicted_results.size() == 0) begin
				report_mismatch("unexpected result", '0, '0);
				return;
			end
			want = predicted_results.pop_front();
			if (r.mode !== want.mode)
				report_mismatch("mode", TIME_W'(want.mode), TIME_W'(r.mode));
			if (r.enter !== want.enter)
				report_mismatch("enter_pulse", TIME_W'(want.enter), TIME_W'(r.enter));
			if (r.leave !== want.leave)
				report_mismatch("leave_pulse", TIME_W'(want.leave), TIME_W'(r.leave));
			if (r.clear !== want.clear)
				report_mismatch("display_clear", TIME_W'(want.clear), TIME_W'(r.clear));
			if (r.shown_v !== want.shown_v)
				report_mismatch("shown_valid", TIME_W'(want.shown_v), TIME_W'(r.shown_v));
			if (r.shown_t !== want.shown_t)
				report_mismatch("shown_time", want.shown_t, r.shown_t);
			if (r.commit_v !== want.commit_v)
				report_mismatch("commit_valid", TIME_W'(want.commit_v), TIME_W'(r.commit_v));
			if (r.commit_t !== want.commit_t)
				report_mismatch("commit_time", want.commit_t, r.commit_t);
		endtask
	endclass

	// Worst case is over twelve hundred polls, each waiting out long sender gaps and receiver stalls.
	localparam int CYCLE_LIMIT = 300000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [TICKS_W-1:0] cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic               enc_a;
	logic               enc_b;
	logic               key_down;
	logic               tick;
	logic [TIME_W-1:0]  now_seconds;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [STATE_W-1:0] mode;
	logic               enter_pulse;
	logic               leave_pulse;
	logic               display_clear;
	logic               shown_valid;
	logic [TIME_W-1:0]  shown_time;
	logic               commit_valid;
	logic [TIME_W-1:0]  commit_time;

	ui_result_tracker tracker;
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	int               polls_sent = 0;
	int               cycle_count = 0;
	logic             line_a = 1'b0;

	knob_clock_edit_controller DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.enc_a        (enc_a),
		.enc_b        (enc_b),
		.key_down     (key_down),
		.tick         (tick),
		.now_seconds  (now_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mode         (mode),
		.enter_pulse  (enter_pulse),
		.leave_pulse  (leave_pulse),
		.display_clear(display_clear),
		.shown_valid  (shown_valid),
		.shown_time   (shown_time),
		.commit_valid (commit_valid),
		.commit_time  (commit_time)
	);

	always #6 clk = ~clk;

	// Stall the result side at random; the rate follows the current phase.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Sample every result transaction at the rising edge and hand it to the tracker.
	always @(posedge clk) begin : result_monitor
		ui_result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.mode     = mode;
			seen.enter    = enter_pulse;
			seen.leave    = leave_pulse;
			seen.clear    = display_clear;
			seen.shown_v  = shown_valid;
			seen.shown_t  = shown_time;
			seen.commit_v = commit_valid;
			seen.commit_t = commit_time;
			tracker.check_result(seen);
		end
	end

	// Watchdog: give up on a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Pick epoch seconds, leaning on both ends of the 32-bit range so the edit math wraps.
	function automatic logic [TIME_W-1:0] pick_now();
		case ($urandom_range(3))
			0:       return TIME_W'($urandom_range(300));
			1:       return '1 - TIME_W'($urandom_range(300));
			default: return $urandom;
		endcase
	endfunction

	// Drive one poll at the falling edge, hold it until the block takes it, then log it.
	task automatic send_poll(input logic a, input logic b, input logic key, input logic tk,
		input logic [TIME_W-1:0] now);
		knob_poll_t p;
		p = {a, b, key, tk, now};
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		enc_a       <= a;
		enc_b       <= b;
		key_down    <= key;
		tick        <= tk;
		now_seconds <= now;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_poll(p);
		line_a = a;
		polls_sent++;
	endtask

	// Flip line A; B picks the direction (right when B ends up different from A).
	task automatic step_knob(input logic right);
		logic new_a;
		new_a = ~line_a;
		send_poll(new_a, right ? ~new_a : new_a, 1'($urandom), 1'($urandom), pick_now());
	endtask

	task automatic release_key();
		send_poll(line_a, 1'($urandom), 1'b0, 1'($urandom), pick_now());
	endtask

	// Hold the key down, either short of the long-press limit or past it, then release.
	task automatic key_press(input logic long_hold);
		int lim;
		int ticks_done;
		logic tk;
		lim = tracker.hold_limit();
		ticks_done = 0;
		if (long_hold) begin
			while (ticks_done < lim) begin
				tk = (lim > 16) ? 1'b1 : ($urandom_range(99) < 70);
				send_poll(line_a, 1'($urandom), 1'b1, tk, pick_now());
				ticks_done += tk;
			end
			// Keep holding a little after expiry: ticks now land with the timer off.
			repeat ($urandom_range(2))
				send_poll(line_a, 1'($urandom), 1'b1, 1'($urandom), pick_now());
		end else begin
			repeat ($urandom_range(1, 4)) begin
				tk = (ticks_done < lim - 1) ? 1'($urandom) : 1'b0;
				send_poll(line_a, 1'($urandom), 1'b1, tk, pick_now());
				ticks_done += tk;
			end
		end
		release_key();
	endtask

	// Steer the predicted state back to clock idle so a well-formed sequence can start.
	task automatic back_to_clock();
		int tries;
		for (tries = 0; tries < 4 && tracker.ui != ST_CLK_IDLE; tries++) begin
			case (tracker.ui)
				ST_ALT:      step_knob(1'($urandom));
				ST_EDT_IDLE: key_press(1'b0);
				default:     release_key();
			endcase
		end
	endtask

	// Long press into edit mode, a few steps, then commit (short) or abandon (long).
	task automatic edit_session();
		back_to_clock();
		key_press(1'b1);
		repeat ($urandom_range(6)) begin
			if ($urandom_range(3) == 0)
				release_key();
			step_knob(1'($urandom));
		end
		if (tracker.hold_limit() <= 16 && $urandom_range(99) < 30)
			key_press(1'b1);
		else
			key_press(1'b0);
	endtask

	task automatic visit_alt();
		back_to_clock();
		step_knob(1'($urandom));
		repeat ($urandom_range(3))
			send_poll(line_a, 1'($urandom), 1'($urandom), 1'($urandom), pick_now());
		step_knob(1'($urandom));
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 4))
			send_poll(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), pick_now());
	endtask

	task automatic random_polls(input int count);
		int stop_at;
		int pick;
		stop_at = polls_sent + count;
		while (polls_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 50)
				edit_session();
			else if (pick < 65)
				visit_alt();
			else if (pick < 80)
				key_press(1'b0);
			else
				noise_burst();
		end
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// Write long_press_ticks with the block idle, and mirror it in the tracker.
	task automatic set_press_ticks(input logic [TICKS_W-1:0] value);
		drain();
		repeat (4) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.press_ticks = value;
	endtask

	initial begin
		tracker     = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		enc_a       = 1'b0;
		enc_b       = 1'b0;
		key_down    = 1'b0;
		tick        = 1'b0;
		now_seconds = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Opening sequence at the reset limit of three ticks.
		// First poll only primes line A: key and tick must be ignored.
		send_poll(1'b1, 1'b0, 1'b1, 1'b1, '1);
		// Hold with a tick on the first poll, one tickless poll, then expire on the third tick.
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, '0);
		send_poll(1'b1, 1'b0, 1'b1, 1'b0, 32'h1234_5678);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'h8000_0000);
		send_poll(1'b1, 1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF);
		// Tick with the timer already stopped.
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0001);
		// Release into edit mode, capturing a time just short of the wrap point.
		send_poll(1'b1, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFE2);
		// Left steps wrap upward past 2^32, right steps wrap back down.
		send_poll(1'b0, 1'b0, 1'b0, 1'b0, 32'hAAAA_AAAA);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'h5555_5555);
		send_poll(1'b0, 1'b1, 1'b0, 1'b0, '0);
		send_poll(1'b1, 1'b0, 1'b0, 1'b1, '1);
		// Short press in edit mode commits the stepped time with seconds cleared.
		send_poll(1'b1, 1'b1, 1'b1, 1'b0, '0);
		send_poll(1'b1, 1'b0, 1'b0, 1'b1, '0);
		// Step into the alternate display; key activity there is ignored; step back out.
		send_poll(1'b0, 1'b1, 1'b0, 1'b0, '0);
		send_poll(1'b0, 1'b0, 1'b1, 1'b1, '1);
		send_poll(1'b0, 1'b1, 1'b0, 1'b0, '0);
		send_poll(1'b1, 1'b1, 1'b0, 1'b0, '0);
		// Short press in clock mode changes nothing.
		send_poll(1'b1, 1'b0, 1'b1, 1'b0, '0);
		send_poll(1'b1, 1'b0, 1'b0, 1'b1, '0);
		// Long press into edit mode at time zero, then a long press that leaves uncommitted.
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, '1);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, '1);
		send_poll(1'b1, 1'b0, 1'b1, 1'b1, '1);
		send_poll(1'b1, 1'b0, 1'b0, 1'b0, '0);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, '1);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, '1);
		send_poll(1'b1, 1'b0, 1'b1, 1'b1, '1);
		send_poll(1'b1, 1'b1, 1'b0, 1'b0, '0);

		// Random phases: vary the limit and the idling on both channels.
		random_polls(300);

		send_idle_pct = 75;
		set_press_ticks(8'd1);
		random_polls(300);

		send_idle_pct  = 0;
		recv_stall_pct = 75;
		set_press_ticks(8'd255);
		random_polls(200);

		send_idle_pct  = 14;
		recv_stall_pct = 14;
		set_press_ticks(8'd0);
		random_polls(200);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_press_ticks(TICKS_W'($urandom_range(2, 12)));
		random_polls(200);

		// Let the last results out, then settle for any stray output.
		drain();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
